// ===== rtl/glj_pkg.sv =====
// Shared types and constants of the greedy line justifier.
// Used by every module of the block; depends on nothing.
package glj_pkg;

    // Field widths of the input and result requests.
    localparam int LEN_W = 7;
    localparam int SP_W = 6;

    // Line positions up to the largest supported maximum width (128) fit 8 bits.
    localparam int WIDTH_W = 8;
    localparam int SUM_W = 10;

    // Words held per line.
    localparam int LINE_SLOTS = 32;
    localparam int CNT_W = $clog2(LINE_SLOTS + 1);
    localparam int IDX_W = $clog2(LINE_SLOTS);

    // Word buffer shared by the front and the back part.
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam int PTR_W = ADDR_W + 1;

    // Command queue between the two parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Defaults.
    localparam int MAX_WIDTH_DEF = 64;
    localparam logic [LEN_W-1:0] WIDTH_RESET = 7'd16;

    typedef struct packed {
        logic [LEN_W-1:0] word_length;
        logic             last_word;
    } glj_in_t;

    typedef struct packed {
        logic [LEN_W-1:0] out_length;
        logic [SP_W-1:0]  spaces_after;
        logic             line_end;
        logic             text_end;
        logic             too_long;
        logic             run_last;
    } glj_out_t;

    // One buffered line that is to be emitted.
    typedef struct packed {
        logic               valid;
        logic               final_line;
        logic [ADDR_W-1:0]  base;
        logic [CNT_W-1:0]   n;
        logic [WIDTH_W-1:0] chars;
    } glj_flush_t;

    // Everything one input request causes, in emission order:
    // the too_long result, then flush f0, then flush f1.
    typedef struct packed {
        logic       too_long;
        logic       tl_text_end;
        glj_flush_t f0;
        glj_flush_t f1;
    } glj_cmd_t;

    // Write port of the word buffer.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  data;
    } glj_wr_t;

endpackage

// ===== rtl/glj_front.sv =====
// Front part: accepts word requests, packs them into lines and issues commands.
// Depends on glj_pkg; writes the word buffer that lives in glj_back.
module glj_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  glj_pkg::glj_in_t            in_data,
    input  logic [glj_pkg::WIDTH_W-1:0] eff_width,
    input  logic                        q_full,
    output logic                        q_push,
    output glj_pkg::glj_cmd_t           q_cmd,
    output glj_pkg::glj_wr_t            mem_wr,
    input  logic [glj_pkg::PTR_W-1:0]   done_ptr
);
    import glj_pkg::*;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIDTH_W-1:0] chars_reg, chars_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;

    logic [PTR_W-1:0]   used;
    logic               accept;
    logic [SUM_W-1:0]   len_s;
    logic [SUM_W-1:0]   w_s;
    logic               too_long;
    logic               need_flush;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  line_b;
    logic [CNT_W-1:0]   line_n;
    logic [WIDTH_W-1:0] line_c;

    // Accept while the queue has room and the buffer has a free entry.
    assign used     = wr_ptr_reg - done_ptr;
    assign in_ready = !q_full && (used != PTR_W'(BUF_DEPTH));
    assign accept   = in_valid && in_ready;

    // Classify the word against the line width and the open line.
    assign len_s      = SUM_W'(in_data.word_length);
    assign w_s        = SUM_W'(eff_width);
    assign too_long   = len_s > w_s;
    assign need_flush = (count_reg != '0) &&
                        ((SUM_W'(chars_reg) + SUM_W'(count_reg) + len_s > w_s) ||
                         (count_reg >= CNT_W'(LINE_SLOTS)));
    assign wr_addr    = wr_ptr_reg[ADDR_W-1:0];

    // The open line after this word has been added.
    always_comb
    begin
        if (need_flush)
        begin
            line_b = wr_addr;
            line_n = CNT_W'(1);
            line_c = WIDTH_W'(in_data.word_length);
        end
        else
        begin
            line_b = base_reg;
            line_n = count_reg + CNT_W'(1);
            line_c = chars_reg + WIDTH_W'(in_data.word_length);
        end
    end

    // Command building and line state update.
    always_comb
    begin
        count_next  = count_reg;
        chars_next  = chars_reg;
        base_next   = base_reg;
        wr_ptr_next = wr_ptr_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        mem_wr.en   = 1'b0;
        mem_wr.addr = wr_addr;
        mem_wr.data = in_data.word_length;
        if (accept)
        begin
            if (too_long)
            begin
                q_push            = 1'b1;
                q_cmd.too_long    = 1'b1;
                q_cmd.tl_text_end = in_data.last_word && (count_reg == '0);
                if (in_data.last_word && (count_reg != '0))
                begin
                    q_cmd.f0.valid      = 1'b1;
                    q_cmd.f0.final_line = 1'b1;
                    q_cmd.f0.base       = base_reg;
                    q_cmd.f0.n          = count_reg;
                    q_cmd.f0.chars      = chars_reg;
                    count_next          = '0;
                    chars_next          = '0;
                    base_next           = wr_addr;
                end
            end
            else
            begin
                mem_wr.en   = 1'b1;
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
                if (need_flush)
                begin
                    q_cmd.f0.valid = 1'b1;
                    q_cmd.f0.base  = base_reg;
                    q_cmd.f0.n     = count_reg;
                    q_cmd.f0.chars = chars_reg;
                end
                if (in_data.last_word)
                begin
                    q_push              = 1'b1;
                    q_cmd.f1.valid      = 1'b1;
                    q_cmd.f1.final_line = 1'b1;
                    q_cmd.f1.base       = line_b;
                    q_cmd.f1.n          = line_n;
                    q_cmd.f1.chars      = line_c;
                    count_next          = '0;
                    chars_next          = '0;
                    base_next           = wr_addr + ADDR_W'(1);
                end
                else
                begin
                    q_push     = need_flush;
                    count_next = line_n;
                    chars_next = line_c;
                    base_next  = line_b;
                end
            end
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            chars_reg  <= '0;
            base_reg   <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            chars_reg  <= chars_next;
            base_reg   <= base_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

endmodule

// ===== rtl/glj_queue.sv =====
// Short command queue that decouples the front part from the back part.
// Depends on glj_pkg for the command type and the depth.
module glj_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  glj_pkg::glj_cmd_t push_cmd,
    input  logic              pop,
    output glj_pkg::glj_cmd_t head,
    output logic              empty,
    output logic              full
);
    import glj_pkg::*;

    glj_cmd_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     cnt_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QPTR_W + 1)'(QDEPTH));

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (QPTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== rtl/glj_div.sv =====
// Restoring divider, one quotient bit per cycle, for the spare-space split.
// Depends on glj_pkg for the divisor width.
module glj_div #(
    parameter int DVD_W = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DVD_W-1:0]          dividend,
    input  logic [glj_pkg::IDX_W-1:0] divisor,
    output logic                      done,
    output logic [DVD_W-1:0]          quotient,
    output logic [glj_pkg::IDX_W-1:0] remainder
);
    import glj_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [IDX_W:0]    trial;
    logic [IDX_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor};

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[IDX_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[IDX_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/glj_back.sv =====
// Back part: takes commands from the queue and emits one result per word.
// Depends on glj_pkg and glj_div; holds the word buffer written by glj_front.
module glj_back #(
    parameter int MAX_WIDTH = glj_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [glj_pkg::WIDTH_W-1:0] eff_width,
    input  logic                        q_empty,
    input  glj_pkg::glj_cmd_t           q_head,
    output logic                        q_pop,
    input  glj_pkg::glj_wr_t            mem_wr,
    output logic [glj_pkg::PTR_W-1:0]   done_ptr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output glj_pkg::glj_out_t           out_data
);
    import glj_pkg::*;

    localparam int DVD_W = $clog2(MAX_WIDTH + 1);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_TL    = 5'b00010,
        B_SETUP = 5'b00100,
        B_DIV   = 5'b01000,
        B_WORD  = 5'b10000
    } back_state_t;

    back_state_t       state_reg, state_next;
    glj_cmd_t          cmd_reg, cmd_next;
    logic              sel_reg, sel_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic              left_reg, left_next;
    logic              over_reg, over_next;
    logic [SP_W-1:0]   pad_reg, pad_next;
    logic [SP_W-1:0]   q_reg, q_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [PTR_W-1:0]  done_ptr_reg, done_ptr_next;
    logic              out_valid_reg, out_valid_next;
    glj_out_t          out_reg, out_next;

    logic [LEN_W-1:0]  buf_mem [BUF_DEPTH];
    logic [LEN_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    glj_flush_t        fl;
    logic              slot_free;
    logic [SUM_W-1:0]  w_s;
    logic              over;
    logic              left;
    logic [SUM_W-1:0]  pad;
    logic [WIDTH_W-1:0] spare;
    logic [CNT_W-1:0]  gaps;
    logic              is_end;
    logic [SP_W-1:0]   sp;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [IDX_W-1:0]  div_r;

    // Word buffer: one write port from the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            buf_mem[mem_wr.addr] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    // The flush being worked on and its line geometry.
    assign fl        = sel_reg ? cmd_reg.f1 : cmd_reg.f0;
    assign slot_free = !out_valid_reg || out_ready;
    assign w_s       = SUM_W'(eff_width);
    assign gaps      = fl.n - CNT_W'(1);
    assign over      = (SUM_W'(fl.chars) + SUM_W'(gaps)) > w_s;
    assign left      = fl.final_line || (fl.n == CNT_W'(1)) || over;
    assign pad       = w_s - SUM_W'(fl.chars) - SUM_W'(gaps);
    assign spare     = eff_width - fl.chars;
    assign is_end    = (i_reg == gaps);

    // Spaces after the current word.
    always_comb
    begin
        if (left_reg)
        begin
            if (!is_end)
            begin
                sp = SP_W'(1);
            end
            else if (over_reg)
            begin
                sp = '0;
            end
            else
            begin
                sp = pad_reg;
            end
        end
        else if (is_end)
        begin
            sp = '0;
        end
        else if (i_reg < CNT_W'(r_reg))
        begin
            sp = q_reg + SP_W'(1);
        end
        else
        begin
            sp = q_reg;
        end
    end

    glj_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DVD_W'(spare)),
        .divisor   (gaps[IDX_W-1:0]),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer over commands, lines and words.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sel_next       = sel_reg;
        i_next         = i_reg;
        left_next      = left_reg;
        over_next      = over_reg;
        pad_next       = pad_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        done_ptr_next  = done_ptr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = fl.base;
        div_start      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    sel_next = !q_head.f0.valid;
                    state_next = q_head.too_long ? B_TL : B_SETUP;
                end
            end
            B_TL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.too_long = 1'b1;
                    out_next.text_end = cmd_reg.tl_text_end;
                    out_next.run_last = !cmd_reg.f0.valid && !cmd_reg.f1.valid;
                    sel_next   = 1'b0;
                    state_next = cmd_reg.f0.valid ? B_SETUP : B_IDLE;
                end
            end
            B_SETUP:
            begin
                // Fetch the first word and fix the spacing mode of the line.
                rd_en     = 1'b1;
                rd_addr   = fl.base;
                i_next    = '0;
                left_next = left;
                over_next = over;
                pad_next  = pad[SP_W-1:0];
                if (left)
                begin
                    state_next = B_WORD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    q_next     = SP_W'(div_q);
                    r_next     = div_r;
                    state_next = B_WORD;
                end
            end
            B_WORD:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_length   = rd_data_reg;
                    out_next.spaces_after = sp;
                    out_next.line_end     = is_end;
                    out_next.text_end     = fl.final_line && is_end;
                    out_next.too_long     = 1'b0;
                    out_next.run_last     = is_end && (sel_reg || !cmd_reg.f1.valid);
                    // Prefetch the next word of the line.
                    rd_en   = 1'b1;
                    rd_addr = fl.base + ADDR_W'(i_reg) + ADDR_W'(1);
                    i_next  = i_reg + CNT_W'(1);
                    if (is_end)
                    begin
                        done_ptr_next = done_ptr_reg + PTR_W'(fl.n);
                        if (!sel_reg && cmd_reg.f1.valid)
                        begin
                            sel_next   = 1'b1;
                            state_next = B_SETUP;
                        end
                        else
                        begin
                            state_next = B_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sel_reg       <= 1'b0;
            i_reg         <= '0;
            done_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            i_reg         <= i_next;
            done_ptr_reg  <= done_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        left_reg <= left_next;
        over_reg <= over_next;
        pad_reg  <= pad_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
    end

    assign done_ptr  = done_ptr_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/greedy_line_justifier_core.sv =====
// Top level of the greedy line justifier: width register, front, queue, back.
// Depends on glj_pkg, glj_front, glj_queue and glj_back.

// Word lengths come in one request per cycle, unless in_ready is low, and are
// packed greedily into lines of line_width positions; each closed line comes
// out as one result request per word with the spaces that follow it. The back
// part runs on its own behind a four-entry command queue and a 64-word buffer:
// it takes each command from the queue, then for each line fetches its first
// word, runs the bit-serial divider for a fully justified line, and emits its
// words in order. A dropped word adds a too_long result of its own, emitted
// before the lines of its command. Input stalls only when the queue or the
// word buffer is full.
module greedy_line_justifier_core #(
    parameter int MAX_WIDTH = glj_pkg::MAX_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  glj_pkg::glj_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output glj_pkg::glj_out_t         out_data,
    input  logic                      cfg_wr_en,
    input  logic [glj_pkg::LEN_W-1:0] cfg_wr_data
);
    import glj_pkg::*;

    logic [LEN_W-1:0]   line_width_reg;
    logic [WIDTH_W-1:0] eff_width;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    glj_cmd_t           q_cmd;
    glj_cmd_t           q_head;
    glj_wr_t            mem_wr;
    logic [PTR_W-1:0]   done_ptr;

    // Line width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_width_reg <= cfg_wr_data;
        end
    end

    // Zero acts as one; widths above the maximum are clamped.
    always_comb
    begin
        if (line_width_reg == '0)
        begin
            eff_width = WIDTH_W'(1);
        end
        else if (WIDTH_W'(line_width_reg) > WIDTH_W'(MAX_WIDTH))
        begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WIDTH_W'(line_width_reg);
        end
    end

    glj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .eff_width (eff_width),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .mem_wr    (mem_wr),
        .done_ptr  (done_ptr)
    );

    glj_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    glj_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_width (eff_width),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .mem_wr    (mem_wr),
        .done_ptr  (done_ptr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/glj_checker.sv =====
// Port-level checks of the greedy line justifier, bound to the top level.
// Depends on glj_pkg and greedy_line_justifier_core.
module glj_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input glj_pkg::glj_out_t out_data
);
    import glj_pkg::*;

    // A waiting result request holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result request changed while stalled");

    // A dropped word carries no length, spacing or line end.
    a_too_long_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.too_long |->
            out_data.out_length == '0 && out_data.spaces_after == '0 &&
            !out_data.line_end)
        else $error("too_long result carries word fields");

    // The end of the text is the last result of its input.
    a_text_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_end |-> out_data.run_last)
        else $error("text_end without run_last");

    // A placed word that ends the text also ends its line.
    a_text_end_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_end && !out_data.too_long |-> out_data.line_end)
        else $error("text_end on a word that does not end its line");

    // The result channel is quiet during reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result request during reset");

endmodule

bind greedy_line_justifier_core glj_checker u_glj_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
